// ===== hw/rtl/iogt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package iogt_pkg;

    localparam int DefMaxTracks = 32;
    localparam int DefCoordBits = 12;

    localparam int CLASS_W   = 7;
    localparam int ID_W      = 16;
    localparam int MISS_W    = 5;
    localparam int THR_W     = 8;
    localparam int CFG_W     = 8;
    localparam int STATUS_W  = 2;
    localparam int ACTIVE_W  = 6;

    localparam logic OP_FRAME  = 1'b0;
    localparam logic OP_DETECT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_MATCH = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NEW   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROP  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FRAME = 2'd3;

    localparam logic CFG_IOU_THR    = 1'b0;
    localparam logic CFG_MAX_MISSED = 1'b1;

    localparam logic [THR_W-1:0]  THR_RESET  = 8'd64;
    localparam logic [MISS_W-1:0] MISS_RESET = 5'd15;
    localparam logic [MISS_W-1:0] MISS_SAT   = 5'd31;
    localparam logic [ID_W-1:0]   ID_FIRST   = 16'd1;
    localparam logic [ID_W-1:0]   ID_LAST    = 16'hFFFF;
    localparam logic [ID_W-1:0]   ID_NONE    = 16'd0;

    typedef struct packed {
        logic meta;
        logic box;
        logic missed;
    } t_tbl_we;

endpackage
`default_nettype wire

// ===== hw/rtl/iogt_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
module iogt_mul #(
    parameter int AW = 35,
    parameter int BW = 35
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [AW-1:0]    i_a,
    input  wire logic [BW-1:0]    i_b,
    output logic                  o_done,
    output logic [AW+BW-1:0]      o_prod
);
    localparam int PW = AW + BW;
    localparam int H  = (BW + 1) / 2;

    logic          r_busy;
    logic          r_phase;
    logic          r_done;
    logic [AW-1:0] r_a;
    logic [BW-1:0] r_b;
    logic [PW-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
            end else if (r_busy) begin
                if (!r_phase) begin
                    r_phase <= 1'b1;
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // low half of b, then high half shifted in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_busy && !r_phase) begin
            r_acc <= PW'(r_a * r_b[H-1:0]);
        end else if (r_busy && r_phase) begin
            r_acc <= r_acc + (PW'(r_a * r_b[BW-1:H]) << H);
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule
`default_nettype wire

// ===== hw/rtl/iogt_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
module iogt_table #(
    parameter int MAX_TRACKS = iogt_pkg::DefMaxTracks,
    parameter int COORD_BITS = iogt_pkg::DefCoordBits
) (
    input  wire logic                                i_clk,
    input  wire iogt_pkg::t_tbl_we                   i_we,
    input  wire logic [$clog2(MAX_TRACKS)-1:0]       i_wr_addr,
    input  wire logic [iogt_pkg::ID_W-1:0]           i_wr_id,
    input  wire logic [iogt_pkg::CLASS_W-1:0]        i_wr_class,
    input  wire logic [4*COORD_BITS+1:0]             i_wr_box,
    input  wire logic [iogt_pkg::MISS_W-1:0]         i_wr_missed,
    input  wire logic [$clog2(MAX_TRACKS)-1:0]       i_rd_addr,
    output logic [iogt_pkg::ID_W-1:0]                o_rd_id,
    output logic [iogt_pkg::CLASS_W-1:0]             o_rd_class,
    output logic [4*COORD_BITS+1:0]                  o_rd_box,
    output logic [iogt_pkg::MISS_W-1:0]              o_rd_missed
);
    import iogt_pkg::*;

    localparam int BXW = 4 * COORD_BITS + 2;

    logic [ID_W-1:0]    mem_id     [MAX_TRACKS];
    logic [CLASS_W-1:0] mem_class  [MAX_TRACKS];
    logic [BXW-1:0]     mem_box    [MAX_TRACKS];
    logic [MISS_W-1:0]  mem_missed [MAX_TRACKS];

    logic [ID_W-1:0]    r_rd_id;
    logic [CLASS_W-1:0] r_rd_class;
    logic [BXW-1:0]     r_rd_box;
    logic [MISS_W-1:0]  r_rd_missed;

    always_ff @(posedge i_clk) begin
        if (i_we.meta) begin
            mem_id[i_wr_addr]    <= i_wr_id;
            mem_class[i_wr_addr] <= i_wr_class;
        end
        if (i_we.box) begin
            mem_box[i_wr_addr] <= i_wr_box;
        end
        if (i_we.missed) begin
            mem_missed[i_wr_addr] <= i_wr_missed;
        end
        r_rd_id     <= mem_id[i_rd_addr];
        r_rd_class  <= mem_class[i_rd_addr];
        r_rd_box    <= mem_box[i_rd_addr];
        r_rd_missed <= mem_missed[i_rd_addr];
    end

    assign o_rd_id     = r_rd_id;
    assign o_rd_class  = r_rd_class;
    assign o_rd_box    = r_rd_box;
    assign o_rd_missed = r_rd_missed;

endmodule
`default_nettype wire

// ===== hw/rtl/iou_greedy_object_tracker_core.sv =====
// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+-------------------------------------------
// in       | input     | i_in_valid / o_in_stall | operation, class_id, box_x/y/w/h
// out      | output    | o_out_valid / i_out_stall | status, track_id, active_tracks
// cfg      | input     | i_cfg_we                | i_cfg_index, i_cfg_data
//
// frame start: a read and a write of each slot's missed count
// detection: a slot of the same class takes up to five passes through the shared
// two-step multiplier
// one request at a time; the result register lets the next request in while it waits
// i_rst_n is synchronous; it clears slot valid and used bits, counters, config and state registers
`timescale 1ns / 1ps
`default_nettype none
module iou_greedy_object_tracker_core #(
    parameter int MAX_TRACKS = iogt_pkg::DefMaxTracks,
    parameter int COORD_BITS = iogt_pkg::DefCoordBits
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_operation,
    input  wire logic [iogt_pkg::CLASS_W-1:0]   i_class_id,
    input  wire logic [COORD_BITS-1:0]          i_box_x,
    input  wire logic [COORD_BITS-1:0]          i_box_y,
    input  wire logic [COORD_BITS:0]            i_box_w,
    input  wire logic [COORD_BITS:0]            i_box_h,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [iogt_pkg::STATUS_W-1:0]       o_status,
    output logic [iogt_pkg::ID_W-1:0]           o_track_id,
    output logic [iogt_pkg::ACTIVE_W-1:0]       o_active_tracks,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_index,
    input  wire logic [iogt_pkg::CFG_W-1:0]     i_cfg_data
);
    import iogt_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int SW   = CB + 1;
    localparam int EW   = CB + 2;
    localparam int AW   = 2 * SW;
    localparam int UW   = AW + 1;
    localparam int PW   = 2 * UW;
    localparam int BXW  = 4 * CB + 2;
    localparam int IW   = $clog2(MAX_TRACKS);
    localparam int CW   = $clog2(MAX_TRACKS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TRACKS - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DA    = 4'd1;
    localparam logic [3:0] S_DAW   = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_TA    = 4'd5;
    localparam logic [3:0] S_IN    = 4'd6;
    localparam logic [3:0] S_TH    = 4'd7;
    localparam logic [3:0] S_C1    = 4'd8;
    localparam logic [3:0] S_C2    = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;
    localparam logic [3:0] S_FR_RD = 4'd11;
    localparam logic [3:0] S_FR_WR = 4'd12;
    localparam logic [3:0] S_EMIT  = 4'd13;

    logic [3:0]          r_state;
    logic [IW-1:0]       r_idx;
    logic [MAX_TRACKS-1:0] r_valid;
    logic [MAX_TRACKS-1:0] r_used;
    logic [CW-1:0]       r_active;
    logic [ID_W-1:0]     r_next_id;
    logic [THR_W-1:0]    r_thr;
    logic [MISS_W-1:0]   r_max_missed;

    logic [CLASS_W-1:0]  r_cls;
    logic [CB-1:0]       r_dx;
    logic [CB-1:0]       r_dy;
    logic [SW-1:0]       r_dw;
    logic [SW-1:0]       r_dh;
    logic [AW-1:0]       r_darea;
    logic [AW-1:0]       r_tarea;
    logic [AW-1:0]       r_inter;
    logic [UW-1:0]       r_uni;
    logic [SW-1:0]       r_ox;
    logic [SW-1:0]       r_oy;
    logic [PW-1:0]       r_p1;

    logic                r_best_ok;
    logic [IW-1:0]       r_best_idx;
    logic [ID_W-1:0]     r_best_id;
    logic [AW-1:0]       r_bi;
    logic [UW-1:0]       r_bu;
    logic                r_free_ok;
    logic [IW-1:0]       r_free_idx;

    logic [STATUS_W-1:0] r_res_status;
    logic [ID_W-1:0]     r_res_id;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [ID_W-1:0]     r_out_id;
    logic [ACTIVE_W-1:0] r_out_active;

    logic                mul_start;
    logic [UW-1:0]       mul_a;
    logic [UW-1:0]       mul_b;
    logic                mul_done;
    logic [PW-1:0]       mul_prod;

    t_tbl_we             tbl_we;
    logic [IW-1:0]       tbl_wr_addr;
    logic [MISS_W-1:0]   tbl_wr_missed;
    logic [ID_W-1:0]     rd_id;
    logic [CLASS_W-1:0]  rd_class;
    logic [BXW-1:0]      rd_box;
    logic [MISS_W-1:0]   rd_missed;

    logic [CB-1:0]       t_x;
    logic [CB-1:0]       t_y;
    logic [SW-1:0]       t_w;
    logic [SW-1:0]       t_h;
    logic [CB-1:0]       lo_x;
    logic [CB-1:0]       lo_y;
    logic [EW-1:0]       hi_x;
    logic [EW-1:0]       hi_y;
    logic [SW-1:0]       ov_x;
    logic [SW-1:0]       ov_y;
    logic [UW-1:0]       n_uni;
    logic                last;
    logic                in_acc;
    logic                out_free;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign last     = (r_idx == LAST_IDX);
    assign out_free = !r_out_valid || !i_out_stall;

    // overlap of the stored box with the detection
    assign t_x = rd_box[BXW-1 -: CB];
    assign t_y = rd_box[BXW-CB-1 -: CB];
    assign t_w = rd_box[2*SW-1 -: SW];
    assign t_h = rd_box[SW-1:0];

    always_comb begin
        lo_x = (t_x > r_dx) ? t_x : r_dx;
        lo_y = (t_y > r_dy) ? t_y : r_dy;
        hi_x = ((EW'(t_x) + EW'(t_w)) < (EW'(r_dx) + EW'(r_dw))) ?
               (EW'(t_x) + EW'(t_w)) : (EW'(r_dx) + EW'(r_dw));
        hi_y = ((EW'(t_y) + EW'(t_h)) < (EW'(r_dy) + EW'(r_dh))) ?
               (EW'(t_y) + EW'(t_h)) : (EW'(r_dy) + EW'(r_dh));
        ov_x = (hi_x > EW'(lo_x)) ? SW'(hi_x - EW'(lo_x)) : '0;
        ov_y = (hi_y > EW'(lo_y)) ? SW'(hi_y - EW'(lo_y)) : '0;
        n_uni = UW'(r_tarea) + UW'(r_darea) - UW'(mul_prod[AW-1:0]);
    end

    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (r_state)
            S_DA: begin
                mul_start = 1'b1;
                mul_a     = UW'(r_dw);
                mul_b     = UW'(r_dh);
            end
            S_CHK: begin
                mul_start = (rd_class == r_cls);
                mul_a     = UW'(t_w);
                mul_b     = UW'(t_h);
            end
            S_TA: begin
                mul_start = mul_done;
                mul_a     = UW'(r_ox);
                mul_b     = UW'(r_oy);
            end
            S_IN: begin
                mul_start = mul_done && (n_uni != '0);
                mul_a     = UW'(r_thr);
                mul_b     = n_uni;
            end
            S_TH: begin
                mul_start = mul_done && r_best_ok && ((PW'(r_inter) << THR_W) > mul_prod);
                mul_a     = UW'(r_inter);
                mul_b     = r_bu;
            end
            S_C1: begin
                mul_start = mul_done;
                mul_a     = UW'(r_bi);
                mul_b     = r_uni;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        tbl_we        = '0;
        tbl_wr_addr   = r_idx;
        tbl_wr_missed = '0;
        case (r_state)
            S_FIN: begin
                if (r_best_ok) begin
                    tbl_wr_addr = r_best_idx;
                    tbl_we.box    = 1'b1;
                    tbl_we.missed = 1'b1;
                end else if (r_free_ok) begin
                    tbl_wr_addr = r_free_idx;
                    tbl_we.meta   = 1'b1;
                    tbl_we.box    = 1'b1;
                    tbl_we.missed = 1'b1;
                end
            end
            S_FR_WR: begin
                tbl_wr_missed = rd_missed + MISS_W'(1);
                tbl_we.missed = r_valid[r_idx] && (rd_missed <= r_max_missed) &&
                                (rd_missed != MISS_SAT);
            end
            default: begin
                tbl_we = '0;
            end
        endcase
    end

    iogt_mul #(
        .AW(UW),
        .BW(UW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    iogt_table #(
        .MAX_TRACKS(MAX_TRACKS),
        .COORD_BITS(COORD_BITS)
    ) u_table (
        .i_clk       (i_clk),
        .i_we        (tbl_we),
        .i_wr_addr   (tbl_wr_addr),
        .i_wr_id     (r_next_id),
        .i_wr_class  (r_cls),
        .i_wr_box    ({r_dx, r_dy, r_dw, r_dh}),
        .i_wr_missed (tbl_wr_missed),
        .i_rd_addr   (r_idx),
        .o_rd_id     (rd_id),
        .o_rd_class  (rd_class),
        .o_rd_box    (rd_box),
        .o_rd_missed (rd_missed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_valid      <= '0;
            r_used       <= '0;
            r_active     <= '0;
            r_next_id    <= ID_FIRST;
            r_thr        <= THR_RESET;
            r_max_missed <= MISS_RESET;
            r_best_ok    <= 1'b0;
            r_free_ok    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IOU_THR:    r_thr        <= i_cfg_data;
                    CFG_MAX_MISSED: r_max_missed <= i_cfg_data[MISS_W-1:0];
                    default:        r_thr        <= r_thr;
                endcase
            end
            if (r_out_valid && !i_out_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_idx     <= '0;
                        r_best_ok <= 1'b0;
                        r_free_ok <= 1'b0;
                        if (i_operation == OP_FRAME) begin
                            r_used  <= '0;
                            r_state <= S_FR_RD;
                        end else begin
                            r_state <= S_DA;
                        end
                    end
                end
                S_DA: begin
                    r_state <= S_DAW;
                end
                S_DAW: begin
                    if (mul_done) begin
                        r_darea <= mul_prod[AW-1:0];
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    if (!r_valid[r_idx] || r_used[r_idx]) begin
                        if (!r_valid[r_idx] && !r_free_ok) begin
                            r_free_ok  <= 1'b1;
                            r_free_idx <= r_idx;
                        end
                        if (last) r_state <= S_FIN;
                        else begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_ox <= ov_x;
                    r_oy <= ov_y;
                    if (rd_class == r_cls) r_state <= S_TA;
                    else if (last) r_state <= S_FIN;
                    else begin
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_RD;
                    end
                end
                S_TA: begin
                    if (mul_done) begin
                        r_tarea <= mul_prod[AW-1:0];
                        r_state <= S_IN;
                    end
                end
                S_IN: begin
                    if (mul_done) begin
                        r_inter <= mul_prod[AW-1:0];
                        r_uni   <= n_uni;
                        if (n_uni != '0) r_state <= S_TH;
                        else if (last) r_state <= S_FIN;
                        else begin
                            r_idx   <= r_idx + IW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_TH: begin
                    if (mul_done) begin
                        if ((PW'(r_inter) << THR_W) > mul_prod && r_best_ok) begin
                            r_state <= S_C1;
                        end else begin
                            if ((PW'(r_inter) << THR_W) > mul_prod) begin
                                r_best_ok  <= 1'b1;
                                r_best_idx <= r_idx;
                                r_best_id  <= rd_id;
                                r_bi       <= r_inter;
                                r_bu       <= r_uni;
                            end
                            if (last) r_state <= S_FIN;
                            else begin
                                r_idx   <= r_idx + IW'(1);
                                r_state <= S_RD;
                            end
                        end
                    end
                end
                S_C1: begin
                    if (mul_done) begin
                        r_p1    <= mul_prod;
                        r_state <= S_C2;
                    end
                end
                S_C2: begin
                    if (mul_done) begin
                        if (r_p1 > mul_prod || (r_p1 == mul_prod && rd_id < r_best_id)) begin
                            r_best_idx <= r_idx;
                            r_best_id  <= rd_id;
                            r_bi       <= r_inter;
                            r_bu       <= r_uni;
                        end
                        if (last) r_state <= S_FIN;
                        else begin
                            r_idx   <= r_idx + IW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_FIN: begin
                    if (r_best_ok) begin
                        r_used[r_best_idx] <= 1'b1;
                        r_res_status       <= ST_MATCH;
                        r_res_id           <= r_best_id;
                    end else if (r_free_ok) begin
                        r_valid[r_free_idx] <= 1'b1;
                        r_used[r_free_idx]  <= 1'b1;
                        r_active            <= r_active + CW'(1);
                        r_res_status        <= ST_NEW;
                        r_res_id            <= r_next_id;
                        r_next_id <= (r_next_id == ID_LAST) ? ID_FIRST : r_next_id + ID_W'(1);
                    end else begin
                        r_res_status <= ST_DROP;
                        r_res_id     <= ID_NONE;
                    end
                    r_state <= S_EMIT;
                end
                S_FR_RD: begin
                    r_state <= S_FR_WR;
                end
                S_FR_WR: begin
                    if (r_valid[r_idx] && rd_missed > r_max_missed) begin
                        r_valid[r_idx] <= 1'b0;
                        r_active       <= r_active - CW'(1);
                    end
                    if (last) begin
                        r_res_status <= ST_FRAME;
                        r_res_id     <= ID_NONE;
                        r_state      <= S_EMIT;
                    end else begin
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_FR_RD;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result payload and captured request fields
    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            r_out_status <= r_res_status;
            r_out_id     <= r_res_id;
            r_out_active <= ACTIVE_W'(r_active);
        end
        if (in_acc) begin
            r_cls <= i_class_id;
            r_dx  <= i_box_x;
            r_dy  <= i_box_y;
            r_dw  <= i_box_w;
            r_dh  <= i_box_h;
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_track_id      = r_out_id;
    assign o_active_tracks = r_out_active;

`ifndef SYNTHESIS
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_active))
        else $error("active count out of step with valid bits");

    a_used_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used & ~r_valid) == '0)
        else $error("used mark on an empty slot");

    a_next_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_id != ID_NONE)
        else $error("next track id is zero");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not presented");

    a_mul_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_start |=> !mul_start)
        else $error("multiplier restarted while busy");
`endif

endmodule
`default_nettype wire

// ===== verif/iou_greedy_object_tracker_core_tb.sv =====
`timescale 1ns / 1ps
module iou_greedy_object_tracker_core_tb;
    import iogt_pkg::*;

    localparam int NTRK = 32;
    localparam int CB = 12;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic           op;
        logic [6:0]     cls;
        logic [CB-1:0]  x;
        logic [CB-1:0]  y;
        logic [CB:0]    w;
        logic [CB:0]    h;
    } t_det;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic [ACTIVE_W-1:0] active;
    } t_res;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_det in_req = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [STATUS_W-1:0] out_status;
    logic [ID_W-1:0] out_id;
    logic [ACTIVE_W-1:0] out_active;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;

    iou_greedy_object_tracker_core uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_operation(in_req.op), .i_class_id(in_req.cls),
        .i_box_x(in_req.x), .i_box_y(in_req.y), .i_box_w(in_req.w), .i_box_h(in_req.h),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_status(out_status), .o_track_id(out_id), .o_active_tracks(out_active),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    // tracker state mirror
    logic [7:0]      thr_q;
    logic [4:0]      maxmiss_q;
    logic            tv[NTRK];
    logic [15:0]     tid[NTRK];
    logic [6:0]      tcls[NTRK];
    logic [CB-1:0]   tx[NTRK], ty[NTRK];
    logic [CB:0]     tw[NTRK], th[NTRK];
    logic [4:0]      tmiss[NTRK];
    logic            tused[NTRK];
    logic [15:0]     next_id;

    t_det pending_reqs[$];
    t_res expected_results[$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    bit failed = 0;
    longint cycles = 0;

    function automatic longint unsigned overlap(longint unsigned p0, longint unsigned s0,
                                                longint unsigned p1, longint unsigned s1);
        longint unsigned lo, hi;
        lo = p0 > p1 ? p0 : p1;
        hi = (p0 + s0) < (p1 + s1) ? (p0 + s0) : (p1 + s1);
        return hi > lo ? hi - lo : 0;
    endfunction

    function automatic t_res track_step(t_det d);
        t_res r;
        int best, freeslot, n;
        longint unsigned inter, uni, b_inter, b_uni, dar;
        logic [127:0] lhs, rhs;
        bit take;
        best = -1;
        freeslot = -1;
        b_inter = 0;
        b_uni = 0;
        n = 0;
        if (d.op == OP_FRAME) begin
            for (int i = 0; i < NTRK; i++) begin
                if (tv[i] && tmiss[i] > maxmiss_q) tv[i] = 0;
                if (tv[i] && tmiss[i] != MISS_SAT) tmiss[i]++;
                tused[i] = 0;
            end
            r.status = ST_FRAME;
            r.id = ID_NONE;
        end else begin
            dar = longint'(d.w) * longint'(d.h);
            for (int i = 0; i < NTRK; i++) begin
                if (!tv[i]) begin
                    if (freeslot < 0) freeslot = i;
                    continue;
                end
                if (tused[i] || tcls[i] != d.cls) continue;
                inter = overlap(tx[i], tw[i], d.x, d.w) * overlap(ty[i], th[i], d.y, d.h);
                uni = longint'(tw[i]) * longint'(th[i]) + dar - inter;
                if (uni == 0) continue;
                if (!(inter * 256 > longint'(thr_q) * uni)) continue;
                if (best < 0) take = 1;
                else begin
                    lhs = 128'(inter) * 128'(b_uni);
                    rhs = 128'(b_inter) * 128'(uni);
                    take = (lhs > rhs) || (lhs == rhs && tid[i] < tid[best]);
                end
                if (take) begin
                    best = i;
                    b_inter = inter;
                    b_uni = uni;
                end
            end
            if (best >= 0) begin
                tx[best] = d.x; ty[best] = d.y; tw[best] = d.w; th[best] = d.h;
                tmiss[best] = 0;
                tused[best] = 1;
                r.status = ST_MATCH;
                r.id = tid[best];
            end else if (freeslot >= 0) begin
                tv[freeslot] = 1;
                tid[freeslot] = next_id;
                tcls[freeslot] = d.cls;
                tx[freeslot] = d.x; ty[freeslot] = d.y;
                tw[freeslot] = d.w; th[freeslot] = d.h;
                tmiss[freeslot] = 0;
                tused[freeslot] = 1;
                r.status = ST_NEW;
                r.id = next_id;
                next_id = (next_id == ID_LAST) ? ID_FIRST : next_id + 1'b1;
            end else begin
                r.status = ST_DROP;
                r.id = ID_NONE;
            end
        end
        for (int i = 0; i < NTRK; i++) n += tv[i];
        r.active = ACTIVE_W'(n);
        return r;
    endfunction

    task automatic add_req(t_det d);
        pending_reqs.insert(pending_reqs.size(), d);
    endtask

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // request driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (!in_valid || !in_stall) begin
                if (in_valid)
                    expected_results.insert(expected_results.size(), track_step(in_req));
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_req <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge clk) begin
        t_res e;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result status=%0d id=%0d", out_status, out_id);
                    failed = 1;
                end else begin
                    e = expected_results.pop_front();
                    if (out_status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, out_status);
                        failed = 1;
                    end
                    if (out_id !== e.id) begin
                        $error("track_id exp %0d got %0d", e.id, out_id);
                        failed = 1;
                    end
                    if (out_active !== e.active) begin
                        $error("active_tracks exp %0d got %0d", e.active, out_active);
                        failed = 1;
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    function automatic t_det frame_req();
        t_det d;
        d = '0;
        d.op = OP_FRAME;
        d.cls = 7'($urandom);
        d.x = CB'($urandom);
        d.y = CB'($urandom);
        d.w = (CB+1)'($urandom);
        d.h = (CB+1)'($urandom);
        return d;
    endfunction

    function automatic t_det det_req(int cls, int x, int y, int w, int h);
        t_det d;
        d.op = OP_DETECT;
        d.cls = 7'(cls);
        d.x = CB'(x);
        d.y = CB'(y);
        d.w = (CB+1)'(w);
        d.h = (CB+1)'(h);
        return d;
    endfunction

    task automatic drain();
        while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (17 * NTRK + 20) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, int val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_IOU_THR) thr_q = 8'(val);
        else maxmiss_q = 5'(val);
        @(posedge clk);
    endtask

    // random frame: motion of earlier boxes, new ones, noise
    task automatic random_part(int cnt, int ncls);
        int bx[8], by[8], bw[8], bh[8], bc[8];
        for (int k = 0; k < 8; k++) begin
            bc[k] = $urandom_range(ncls - 1);
            bx[k] = $urandom_range(4000);
            by[k] = $urandom_range(4000);
            bw[k] = $urandom_range(1, 300);
            bh[k] = $urandom_range(1, 300);
        end
        for (int n = 0; n < cnt; n++) begin
            int k;
            k = $urandom_range(7);
            case ($urandom_range(9))
                0: add_req(frame_req());
                1: add_req(det_req($urandom_range(127), $urandom, $urandom,
                                   $urandom, $urandom));
                2: add_req(det_req(bc[k], 4095 - $urandom_range(3),
                                   $urandom_range(4095), 4096, $urandom_range(2)));
                default: begin
                    bx[k] = (bx[k] + $urandom_range(20) - 10) & 12'hFFF;
                    by[k] = (by[k] + $urandom_range(20) - 10) & 12'hFFF;
                    add_req(det_req(bc[k], bx[k], by[k],
                                    bw[k] + $urandom_range(4),
                                    bh[k] + $urandom_range(4)));
                end
            endcase
            if (n % 12 == 11) add_req(frame_req());
        end
    endtask

    initial begin
        thr_q = THR_RESET;
        maxmiss_q = MISS_RESET;
        next_id = ID_FIRST;
        for (int i = 0; i < NTRK; i++) begin
            tv[i] = 0;
            tused[i] = 0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: new, match, tie, empty box, class extremes, overflow
        add_req(det_req(0, 0, 0, 4096, 4096));
        add_req(det_req(0, 0, 0, 4096, 4096));
        add_req(frame_req());
        add_req(det_req(0, 0, 0, 4096, 4096));
        add_req(det_req(127, 4095, 4095, 1, 1));
        add_req(det_req(79, 100, 100, 0, 50));
        add_req(frame_req());
        add_req(det_req(79, 100, 100, 0, 50));
        add_req(det_req(0, 10, 10, 8191, 8191));
        for (int i = 0; i < 26; i++) add_req(det_req(5, i * 100, 0, 50, 50));
        drain();

        // long hold-off so the block backs up
        hold_cycles = 3000;
        for (int i = 0; i < 6; i++) add_req(det_req(5, i * 100, 0, 50, 50));
        drain();

        write_reg(CFG_MAX_MISSED, 0);
        write_reg(CFG_IOU_THR, 0);
        for (int i = 0; i < 3; i++) add_req(frame_req());
        random_part(60, 4);
        drain();

        send_idle_pct = 21;
        recv_idle_pct = 64;
        write_reg(CFG_IOU_THR, 255);
        write_reg(CFG_MAX_MISSED, 31);
        for (int i = 0; i < 40; i++) add_req(frame_req());
        random_part(100, 6);
        drain();

        send_idle_pct = 64;
        recv_idle_pct = 21;
        write_reg(CFG_IOU_THR, 128);
        write_reg(CFG_MAX_MISSED, 3);
        random_part(120, 3);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_IOU_THR, $urandom_range(255));
        write_reg(CFG_MAX_MISSED, $urandom_range(30));
        random_part(120, 2);
        drain();

        if (!failed) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/iogt_pkg.sv
hw/rtl/iogt_mul.sv
hw/rtl/iogt_table.sv
hw/rtl/iou_greedy_object_tracker_core.sv
verif/iou_greedy_object_tracker_core_tb.sv
